// ----- rtl/point_in_polygon_test_assert.svh -----
// Assertion macros used by the point-in-polygon test RTL.
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define PIPT_ASSERT_IMP(label, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every edge including reset.
`define PIPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pipt_pkg.sv -----
// Shared widths, constants and types of the point-in-polygon test.
package pipt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int REL_W       = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * REL_W;
  localparam int TOL_W       = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // A vertex relative to the query point.
  typedef struct packed {
    logic [REL_W-1:0] x;
    logic [REL_W-1:0] y;
  } rel_pt_t;

  // One classified vertex: the edge from the previous vertex and, on the
  // last vertex, the closing edge back to the first one.
  typedef struct packed {
    logic    start;
    logic    last;
    logic    has_prev;
    logic    hit;
    rel_pt_t prev;
    rel_pt_t cur;
    rel_pt_t first;
  } edge_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ----- rtl/pipt_if.sv -----
// Handshake channels of the point-in-polygon test: vertices, results, configuration.
interface pipt_in_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [pipt_pkg::COORD_WIDTH-1:0]     point_x;
  logic signed [pipt_pkg::COORD_WIDTH-1:0]     point_y;
  logic signed [pipt_pkg::COORD_WIDTH-1:0]     vertex_x;
  logic signed [pipt_pkg::COORD_WIDTH-1:0]     vertex_y;
  logic                                        last_vertex;

  modport source (output valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
                  input ready);
  modport sink   (input valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
                  output ready);
endinterface

interface pipt_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic on_vertex;

  modport source (output valid, inside_res, on_vertex, input ready);
  modport sink   (input valid, inside_res, on_vertex, output ready);
endinterface

interface pipt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pipt_pkg::TOL_W-1:0]    vertex_tolerance;

  modport source (output valid, vertex_tolerance, input ready);
  modport sink   (input valid, vertex_tolerance, output ready);
endinterface

// ----- rtl/point_in_polygon_test.sv -----
// Top level of the crossing-number point-in-polygon test.
// Result path: a last vertex passes the queue, the product stage s1 and the result register.
// Throughput: one vertex per cycle while the queue is not full, set by the four-entry queue and the
// two-stage edge unit (products, then compare and parity).
// Reset (synchronous, rst high): no polygon in progress, queue and stages
// empty, no result pending, vertex tolerance back to one LSB.
module point_in_polygon_test (
  input  logic        clk,
  input  logic        rst,
  pipt_in_if.sink     vtx,
  pipt_out_if.source  res,
  pipt_cfg_if.sink    cfg
);

  `include "point_in_polygon_test_assert.svh"

  // The tolerance register accepts a write in every cycle; the user must write it only while the
  // block is idle, so no item sees it change mid-polygon; the block itself does not enforce this.
  logic [pipt_pkg::TOL_W-1:0] tolerance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= pipt_pkg::TOL_RESET;
    end else if (cfg.valid && cfg.ready) begin
      tolerance <= cfg.vertex_tolerance;
    end
  end

  // The front makes each vertex relative to the query point, checks it
  // against the tolerance and packs the edges it closes into one item.
  logic                  q_push;
  pipt_pkg::edge_job_t   q_push_job;
  logic                  q_pop;
  pipt_pkg::edge_job_t   q_head_job;
  pipt_pkg::queue_stat_t q_stat;

  pipt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .vtx      (vtx),
    .tolerance(tolerance),
    .q_stat   (q_stat),
    .push     (q_push),
    .push_job (q_push_job)
  );

  // The queue lets the front keep taking vertices while the back waits
  // for a result to be taken downstream.
  pipt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(q_push_job),
    .pop     (q_pop),
    .head_job(q_head_job),
    .stat    (q_stat)
  );

  // The back forms the cross products, decides each crossing by sign and
  // keeps the parity; the last vertex of a polygon loads the result.
  pipt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(!q_stat.empty),
    .head_job  (q_head_job),
    .pop       (q_pop),
    .res       (res)
  );

  // A full queue must hold off the vertex channel.
  `PIPT_ASSERT_IMP(a_full_stalls, rst, q_stat.full, !vtx.ready, "vertex taken while queue full")
  // The back never pulls from an empty queue.
  `PIPT_ASSERT_IMP(a_no_pop_empty, rst, q_stat.empty, !q_pop, "pop from empty queue")
  // A vertex hit always makes the point inside.
  `PIPT_ASSERT_IMP(a_hit_inside, rst, res.valid && res.on_vertex, res.inside_res,
                   "vertex hit reported outside")
  // Reset leaves no result pending and the queue empty.
  `PIPT_ASSERT_NXT(a_reset_clear, rst, !res.valid && q_stat.empty, "state not cleared by reset")

endmodule

// ----- rtl/pipt_queue.sv -----
// Short queue of classified vertices between the front and the back.
module pipt_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pipt_pkg::edge_job_t   push_job,
  input  logic                  pop,
  output pipt_pkg::edge_job_t   head_job,
  output pipt_pkg::queue_stat_t stat
);

  pipt_pkg::edge_job_t                slots [pipt_pkg::QUEUE_DEPTH];
  logic [pipt_pkg::QPTR_W-1:0]        wr_ptr;
  logic [pipt_pkg::QPTR_W-1:0]        rd_ptr;
  logic [pipt_pkg::QCNT_W-1:0]        count;
  logic [pipt_pkg::QCNT_W-1:0]        count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + pipt_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - pipt_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + pipt_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + pipt_pkg::QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  assign head_job   = slots[rd_ptr];
  assign stat.full  = (count == pipt_pkg::QCNT_W'(pipt_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// ----- rtl/pipt_front.sv -----
// Front part: accepts vertices, makes them relative, checks for a vertex hit.
module pipt_front (
  input  logic                         clk,
  input  logic                         rst,
  pipt_in_if.sink                      vtx,
  input  logic [pipt_pkg::TOL_W-1:0]   tolerance,
  input  pipt_pkg::queue_stat_t        q_stat,
  output logic                         push,
  output pipt_pkg::edge_job_t          push_job
);

  logic                                 in_progress;
  logic [pipt_pkg::COORD_WIDTH-1:0]     query_x;
  logic [pipt_pkg::COORD_WIDTH-1:0]     query_y;
  pipt_pkg::rel_pt_t                    first_rel;
  pipt_pkg::rel_pt_t                    prev_rel;
  logic                                 vertex_hit;

  logic [pipt_pkg::COORD_WIDTH-1:0]     qx;
  logic [pipt_pkg::COORD_WIDTH-1:0]     qy;
  pipt_pkg::rel_pt_t                    rel;
  logic [pipt_pkg::REL_W-1:0]           mag_x;
  logic [pipt_pkg::REL_W-1:0]           mag_y;
  logic [pipt_pkg::REL_W-1:0]           tol_ext;
  logic                                 hit_now;
  logic                                 hit_acc;

  assign vtx.ready = !q_stat.full;
  assign push      = vtx.valid && vtx.ready;

  always_comb begin
    qx      = in_progress ? query_x : vtx.point_x;
    qy      = in_progress ? query_y : vtx.point_y;
    rel.x   = {vtx.vertex_x[pipt_pkg::COORD_WIDTH-1], vtx.vertex_x}
            - {qx[pipt_pkg::COORD_WIDTH-1], qx};
    rel.y   = {vtx.vertex_y[pipt_pkg::COORD_WIDTH-1], vtx.vertex_y}
            - {qy[pipt_pkg::COORD_WIDTH-1], qy};
    mag_x   = rel.x[pipt_pkg::REL_W-1] ? (~rel.x + pipt_pkg::REL_W'(1)) : rel.x;
    mag_y   = rel.y[pipt_pkg::REL_W-1] ? (~rel.y + pipt_pkg::REL_W'(1)) : rel.y;
    tol_ext = {(pipt_pkg::REL_W - pipt_pkg::TOL_W)'(0), tolerance};
    hit_now = (mag_x < tol_ext) && (mag_y < tol_ext);
    hit_acc = (in_progress && vertex_hit) || hit_now;

    push_job.start    = !in_progress;
    push_job.last     = vtx.last_vertex;
    push_job.has_prev = in_progress;
    push_job.hit      = hit_acc;
    push_job.prev     = prev_rel;
    push_job.cur      = rel;
    push_job.first    = in_progress ? first_rel : rel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_progress <= 1'b0;
      vertex_hit  <= 1'b0;
    end else if (push) begin
      in_progress <= !vtx.last_vertex;
      vertex_hit  <= hit_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!in_progress) begin
        query_x   <= vtx.point_x;
        query_y   <= vtx.point_y;
        first_rel <= rel;
      end
      prev_rel <= rel;
    end
  end

endmodule

// ----- rtl/pipt_back.sv -----
// Back part: evaluates edge crossings, keeps the parity and emits the result.
module pipt_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  pipt_pkg::edge_job_t   head_job,
  output logic                  pop,
  pipt_out_if.source            res
);

  typedef struct packed {
    logic                         start;
    logic                         last;
    logic                         hit;
    logic                         a_cross;
    logic                         a_up2;
    logic                         b_cross;
    logic                         b_up2;
    logic [pipt_pkg::PROD_W-1:0]  pa1;
    logic [pipt_pkg::PROD_W-1:0]  pa2;
    logic [pipt_pkg::PROD_W-1:0]  pb1;
    logic [pipt_pkg::PROD_W-1:0]  pb2;
  } prod_stage_t;

  prod_stage_t  s1;
  prod_stage_t  s1_next;
  logic         s1_valid;
  logic         parity;

  logic         up_prev;
  logic         up_cur;
  logic         up_first;
  logic         out_free;
  logic         fire2;
  logic         tog_a;
  logic         tog_b;
  logic         parity_next;

  logic signed [pipt_pkg::PROD_W-1:0] pa1;
  logic signed [pipt_pkg::PROD_W-1:0] pa2;
  logic signed [pipt_pkg::PROD_W-1:0] pb1;
  logic signed [pipt_pkg::PROD_W-1:0] pb2;

  // Cross products: edge from previous to current, and closing edge.
  assign pa1 = $signed(head_job.prev.x) * $signed(head_job.cur.y);
  assign pa2 = $signed(head_job.cur.x) * $signed(head_job.prev.y);
  assign pb1 = $signed(head_job.cur.x) * $signed(head_job.first.y);
  assign pb2 = $signed(head_job.first.x) * $signed(head_job.cur.y);

  always_comb begin
    up_prev          = !head_job.prev.y[pipt_pkg::REL_W-1] && (head_job.prev.y != '0);
    up_cur           = !head_job.cur.y[pipt_pkg::REL_W-1] && (head_job.cur.y != '0);
    up_first         = !head_job.first.y[pipt_pkg::REL_W-1] && (head_job.first.y != '0);
    s1_next.start    = head_job.start;
    s1_next.last     = head_job.last;
    s1_next.hit      = head_job.hit;
    s1_next.a_cross  = head_job.has_prev && (up_prev != up_cur);
    s1_next.a_up2    = up_cur;
    s1_next.b_cross  = head_job.last && (up_cur != up_first);
    s1_next.b_up2    = up_first;
    s1_next.pa1      = pa1;
    s1_next.pa2      = pa2;
    s1_next.pb1      = pb1;
    s1_next.pb2      = pb2;
  end

  assign out_free = !res.valid || res.ready;
  assign fire2    = s1_valid && (!s1.last || out_free);
  assign pop      = head_valid && (!s1_valid || fire2);

  always_comb begin
    tog_a = s1.a_cross &&
            ((s1.a_up2 && ($signed(s1.pa1) > $signed(s1.pa2))) ||
             (!s1.a_up2 && ($signed(s1.pa1) < $signed(s1.pa2))));
    tog_b = s1.b_cross &&
            ((s1.b_up2 && ($signed(s1.pb1) > $signed(s1.pb2))) ||
             (!s1.b_up2 && ($signed(s1.pb1) < $signed(s1.pb2))));
    parity_next = (s1.start ? 1'b0 : parity) ^ tog_a ^ tog_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      parity    <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (fire2) begin
        s1_valid <= 1'b0;
      end
      if (fire2) begin
        parity <= parity_next;
      end
      if (fire2 && s1.last) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1 <= s1_next;
    end
    if (fire2 && s1.last) begin
      res.inside_res <= parity_next || s1.hit;
      res.on_vertex  <= s1.hit;
    end
  end

endmodule
